[sv/aed_pkg.sv]
// Shared constants and types of the audio echo delay line.
package aed_pkg;

  localparam int unsigned SAMPLE_W          = 16;
  localparam int unsigned CFG_W             = 15;
  localparam int unsigned CFG_IDX_W         = 1;
  localparam int unsigned DEFAULT_MAX_DELAY = 16384;

  localparam logic [CFG_W-1:0] RESET_ECHO_DELAY = CFG_W'(8000);
  localparam logic [CFG_W-1:0] RESET_VOLUME_DIV = CFG_W'(4);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_DELAY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_DIV = 1'b1;

  // The divider retires one quotient bit per cycle.
  localparam int unsigned DIV_STEPS = SAMPLE_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic                start;
    logic [SAMPLE_W-1:0] dividend;
    logic [CFG_W-1:0]    divisor;
  } aed_div_req_t;

  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] quotient;
  } aed_div_rsp_t;

endpackage

[sv/aed_if.sv]
// Handshake channel interfaces of the audio echo delay line.
interface aed_sample_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic signed [aed_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output kind, output sample_in, input ready);
  modport sink (input valid, input kind, input sample_in, output ready);
endinterface

interface aed_result_if;
  logic                            valid;
  logic                            ready;
  logic signed [aed_pkg::SAMPLE_W-1:0] sample_out;
  logic                            last_of_stream;

  modport source (output valid, output sample_out, output last_of_stream, input ready);
  modport sink (input valid, input sample_out, input last_of_stream, output ready);
endinterface

interface aed_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [aed_pkg::CFG_IDX_W-1:0]    index;
  logic [aed_pkg::CFG_W-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/aed_divider.sv]
// Restoring unsigned divider that produces one quotient bit per cycle.
module aed_divider (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  aed_pkg::aed_div_req_t req_i,
  output aed_pkg::aed_div_rsp_t rsp_o
);
  import aed_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [SAMPLE_W-1:0]  dvd_q, dvd_d;
  logic [CFG_W-1:0]     rem_q, rem_d;
  logic [CFG_W-1:0]     div_q, div_d;
  logic [CFG_W:0]       trial;
  logic [CFG_W:0]       diff;
  logic                 fits;

  // The partial remainder stays below the divisor, so it fits in CFG_W bits.
  assign trial = {rem_q, dvd_q[SAMPLE_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS);
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
      dvd_d = {dvd_q[SAMPLE_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

[sv/audio_echo_delay_line.sv]
// Top level of the audio echo delay line: sequencer, divider, echo ring and output register.
//
// The block adds one echo to a stream of signed 16-bit samples. Items arrive on
// in_i (kind 0 carries a sample, kind 1 is a flush tick that drains the echo
// tail) and each item yields exactly one item on out_o. The cfg_i channel
// writes echo_delay (index 0) and volume_divisor (index 1); it is always ready
// and must only be used while the block is idle.
// Every sample is divided by volume_divisor, truncating toward zero, in a
// serial divider that retires one quotient bit per cycle, and the quotient is
// stored in an echo ring held in a single-port-write, registered-read memory.
// Once the ring has been filled, each output is the sample plus the scaled
// sample from echo_delay items earlier, wrapping modulo 2^16.
// From acceptance, an item passes through sixteen divider steps, a state that
// waits to see the divider finish and a finishing step that writes the ring
// and the output register. in_i is ready again as the result is offered, so
// the block takes no new item until the one before it has been finished.
// A result waiting in the output register does not block the next acceptance;
// only when a second result is finished before out_o takes the first does the
// block hold it back. Reset clears position, fill and flush state and loads
// the default registers; the ring contents are not cleared and need no pass.
module audio_echo_delay_line #(
  parameter int unsigned MAX_DELAY = aed_pkg::DEFAULT_MAX_DELAY
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  aed_sample_if.sink    in_i,
  aed_result_if.source  out_o,
  aed_cfg_if.sink       cfg_i
);
  import aed_pkg::*;

  localparam int unsigned AW    = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int unsigned DLY_W = $clog2(MAX_DELAY + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;

  // Configuration registers.
  logic [CFG_W-1:0] echo_delay_q;
  logic [CFG_W-1:0] volume_div_q;

  // Delay actually in use: zero counts as one, and it never exceeds the ring.
  logic [16:0]      dly_wide;
  logic [DLY_W-1:0] dly;
  logic [CFG_W-1:0] div_eff;

  always_comb begin
    if (echo_delay_q == '0) begin
      dly_wide = 17'd1;
    end else if ({2'b00, echo_delay_q} > 17'(MAX_DELAY)) begin
      dly_wide = 17'(MAX_DELAY);
    end else begin
      dly_wide = {2'b00, echo_delay_q};
    end
  end

  assign dly     = dly_wide[DLY_W-1:0];
  assign div_eff = (volume_div_q == '0) ? CFG_W'(1) : volume_div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_delay_q <= RESET_ECHO_DELAY;
      volume_div_q <= RESET_VOLUME_DIV;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_ECHO_DELAY: echo_delay_q <= cfg_i.data;
        REG_VOLUME_DIV: volume_div_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // Stream state.
  logic [AW-1:0]    pos_q;
  logic             filled_q;
  logic [DLY_W-1:0] flush_cnt_q;
  logic             flush_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] echo_rd_q;

  logic in_accept;
  logic flush_now;
  logic signed [SAMPLE_W-1:0] sample_now;
  logic [DLY_W-1:0] pos_wide;
  logic             pos_wrap;
  logic [AW-1:0]    pos_adj;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;

  // A data item during a flush is treated as another flush tick.
  assign flush_now  = in_i.kind || (flush_cnt_q != '0);
  assign sample_now = flush_now ? '0 : in_i.sample_in;

  // After the delay was shrunk the position may lie past the ring in use.
  assign pos_wide = DLY_W'(pos_q);
  assign pos_wrap = pos_wide >= dly;
  assign pos_adj  = pos_wrap ? '0 : pos_q;

  // Divider hookup: the magnitude is divided, the sign is restored afterwards.
  aed_div_req_t div_req;
  aed_div_rsp_t div_rsp;

  assign div_req.start    = in_accept;
  assign div_req.dividend = sample_now[SAMPLE_W-1] ? (~sample_now + 1'b1) : sample_now;
  assign div_req.divisor  = div_eff;

  aed_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Finishing step: runs once the output register can take the result.
  logic                finish;
  logic [SAMPLE_W-1:0] scaled;
  logic [SAMPLE_W-1:0] result;
  logic [DLY_W-1:0]    pos_inc;
  logic [DLY_W-1:0]    flush_inc;
  logic                tail_end;
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_sample_q;
  logic                out_last_q;

  assign finish    = (state_q == ST_FINISH) && (!out_valid_q || out_o.ready);
  assign scaled    = sample_q[SAMPLE_W-1] ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;
  assign result    = SAMPLE_W'(sample_q) + (filled_q ? echo_rd_q : '0);
  assign pos_inc   = pos_wide + 1'b1;
  assign flush_inc = flush_cnt_q + 1'b1;
  assign tail_end  = flush_q && (flush_inc >= dly);

  // Echo ring. Entries are read on every accepted item; the read value is added only once the ring has been filled.
  logic [SAMPLE_W-1:0] echo_mem [MAX_DELAY];

  always_ff @(posedge clk_i) begin
    if (finish) begin
      echo_mem[pos_q] <= scaled;
    end
    if (in_accept) begin
      echo_rd_q <= echo_mem[pos_adj];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_accept) state_d = ST_DIV;
      ST_DIV:    if (div_rsp.done) state_d = ST_FINISH;
      ST_FINISH: if (finish) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      filled_q    <= 1'b0;
      flush_cnt_q <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        out_valid_q <= 1'b1;
        out_last_q  <= tail_end;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_accept) begin
        flush_q <= flush_now;
        pos_q   <= pos_adj;
        if (pos_wrap) begin
          filled_q <= 1'b1;
        end
      end else if (finish) begin
        if (tail_end) begin
          // Final tail item: the stream starts over from an empty ring.
          pos_q       <= '0;
          filled_q    <= 1'b0;
          flush_cnt_q <= '0;
        end else begin
          if (pos_inc >= dly) begin
            pos_q    <= '0;
            filled_q <= 1'b1;
          end else begin
            pos_q <= pos_inc[AW-1:0];
          end
          if (flush_q) begin
            flush_cnt_q <= flush_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= sample_now;
    end
    if (finish) begin
      out_sample_q <= result;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.sample_out     = out_sample_q;
  assign out_o.last_of_stream = out_last_q;

endmodule
